/* hw/rtl/nhs_pkg.sv */
// ----------------------------------------------------------------------------
// nhs_pkg: shared types and constants for the node heartbeat supervisor
// Item formats, frame/report/message codes, register map and reset values.
// ----------------------------------------------------------------------------
package nhs_pkg;

    localparam int NODE_COUNT   = 4;
    localparam int NODE_IDS     = 4;
    localparam int NODE_MATCH_N = (NODE_COUNT < NODE_IDS) ? NODE_COUNT : NODE_IDS;
    localparam int MASK_W       = 4;
    localparam int ID_W         = 16;
    localparam int MS_W         = 16;
    localparam int TIMER_W      = 32;
    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 16;

    localparam logic [MASK_W-1:0] NODE_MASK_ALL =
        MASK_W'(((1 << NODE_COUNT) - 1) & ((1 << MASK_W) - 1));

    // 3 s between requests, 1 s to answer
    localparam logic [MS_W-1:0]   INTERVAL_MS_RESET     = 16'd3000;
    localparam logic [MS_W-1:0]   REPLY_WINDOW_MS_RESET = 16'd1000;
    localparam logic [MASK_W-1:0] EXPECTED_MASK_RESET   = 4'hF;
    localparam logic              FAULT_MODE_RESET      = 1'b1;
    localparam logic [ID_W-1:0]   CAR_ID_RESET          = 16'd1;
    localparam logic [ID_W-1:0]   FLOOR_ONE_ID_RESET    = 16'd2;
    localparam logic [ID_W-1:0]   FLOOR_TWO_ID_RESET    = 16'd3;
    localparam logic [ID_W-1:0]   FLOOR_THREE_ID_RESET  = 16'd4;

    typedef enum logic {
        CMD_TICK = 1'b0,
        CMD_MSG  = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        MSG_OK      = 2'd0,
        MSG_REQUEST = 2'd1,
        MSG_ERROR   = 2'd2,
        MSG_OTHER   = 2'd3
    } msg_kind_t;

    typedef enum logic [1:0] {
        FRAME_NONE    = 2'd0,
        FRAME_REQUEST = 2'd1,
        FRAME_OK      = 2'd2
    } frame_t;

    typedef enum logic [1:0] {
        REPORT_NONE    = 2'd0,
        REPORT_TIMEOUT = 2'd1,
        REPORT_ERROR   = 2'd2
    } report_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_INTERVAL     = 3'd0,
        REG_REPLY_WINDOW = 3'd1,
        REG_EXPECTED     = 3'd2,
        REG_FAULT_MODE   = 3'd3,
        REG_CAR_ID       = 3'd4,
        REG_FLOOR_ONE_ID = 3'd5,
        REG_FLOOR_TWO_ID = 3'd6,
        REG_FLOOR_THR_ID = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic            command;
        logic [MS_W-1:0] elapsed_ms;
        logic [1:0]      msg_kind;
        logic [ID_W-1:0] sender_id;
    } in_item_t;

    typedef struct packed {
        logic [1:0]        send_frame;
        logic [1:0]        report;
        logic [MASK_W-1:0] missed_mask;
        logic [MASK_W-1:0] received_mask;
        logic              window_open;
        logic              fault_raised;
        logic              fault_latched;
    } out_item_t;

    // saturating timer advance
    function automatic logic [TIMER_W-1:0] sat_add(
        input logic [TIMER_W-1:0] a,
        input logic [MS_W-1:0]    b
    );
        logic [TIMER_W:0] s;
        s = {1'b0, a} + {{(TIMER_W + 1 - MS_W){1'b0}}, b};
        return s[TIMER_W] ? {TIMER_W{1'b1}} : s[TIMER_W-1:0];
    endfunction

endpackage

/* hw/rtl/nhs_chan_if.sv */
// ----------------------------------------------------------------------------
// nhs_chan_if: valid/ready channel
// Carries one item per handshake; payload type set per instance.
// ----------------------------------------------------------------------------
interface nhs_chan_if #(
    parameter type item_t = logic
);
    logic  valid;
    logic  ready;
    item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* hw/rtl/node_heartbeat_supervisor_top.sv */
// ----------------------------------------------------------------------------
// node_heartbeat_supervisor_top: heartbeat supervisor for four bus nodes
// Ticks run the request interval and reply window; messages answer requests,
// mark replies and report node errors. One result item per input item.
// ----------------------------------------------------------------------------
//  port     dir   handshake          payload
//  in_ch    in    valid/ready        in_item_t  (command, elapsed, kind, source)
//  out_ch   out   valid/ready        out_item_t (frame, report, masks, flags)
//  cfg_*    in    cfg_we, no ready   cfg_index, cfg_data
//
//  One item per cycle while in_ch.ready is high; its result is registered.
//  Result register plus one skid entry: in_ch.ready is low only when both hold
//  results that out_ch has not taken.
//  Reset restores register defaults, clears timers, masks, window and fault.
// ----------------------------------------------------------------------------
module node_heartbeat_supervisor_top
    import nhs_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    nhs_chan_if.sink               in_ch,
    nhs_chan_if.source             out_ch,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    // configuration
    logic [MS_W-1:0]   interval_reg;
    logic [MS_W-1:0]   window_len_reg;
    logic [MASK_W-1:0] expected_mask_reg;
    logic              fault_mode_reg;
    logic [ID_W-1:0]   node_id_reg [NODE_IDS];

    // supervisor state
    logic [TIMER_W-1:0] interval_elapsed_reg, interval_elapsed_next;
    logic [TIMER_W-1:0] window_elapsed_reg,   window_elapsed_next;
    logic               window_open_reg,      window_open_next;
    logic [MASK_W-1:0]  expected_latch_reg,   expected_latch_next;
    logic [MASK_W-1:0]  received_reg,         received_next;
    logic [MASK_W-1:0]  missed_reg,           missed_next;
    logic               fault_reg,            fault_next;

    // output buffering
    out_item_t out_item_reg;
    logic      out_valid_reg;
    out_item_t skid_item_reg;
    logic      skid_valid_reg;

    in_item_t          item;
    out_item_t         result;
    logic              accept;
    logic              take;
    logic [MASK_W-1:0] src_match;

    assign item         = in_ch.payload;
    assign in_ch.ready  = !skid_valid_reg;
    assign accept       = in_ch.valid && !skid_valid_reg;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.payload = out_item_reg;
    assign take         = out_valid_reg && out_ch.ready;

    // first match wins, car first
    always_comb
    begin
        src_match = '0;
        for (int i = NODE_MATCH_N - 1; i >= 0; i--)
        begin
            if (node_id_reg[i] == item.sender_id)
            begin
                src_match = MASK_W'(1) << i;
            end
        end
    end

    always_comb
    begin
        logic [TIMER_W-1:0] win_sum;
        logic [TIMER_W-1:0] int_sum;
        logic [MASK_W-1:0]  reported;
        logic [MASK_W-1:0]  lost;
        logic [MASK_W-1:0]  rcv_tmp;
        logic               fail;
        logic [1:0]         frame;
        logic [1:0]         rep;

        interval_elapsed_next = interval_elapsed_reg;
        window_elapsed_next   = window_elapsed_reg;
        window_open_next      = window_open_reg;
        expected_latch_next   = expected_latch_reg;
        received_next         = received_reg;
        missed_next           = missed_reg;
        reported              = '0;
        fail                  = 1'b0;
        frame                 = FRAME_NONE;
        rep                   = REPORT_NONE;
        win_sum               = sat_add(window_elapsed_reg, item.elapsed_ms);
        int_sum               = sat_add(interval_elapsed_reg, item.elapsed_ms);
        lost                  = expected_latch_reg & ~received_reg;
        rcv_tmp               = received_reg | src_match;

        if (item.command == CMD_TICK)
        begin
            if (window_open_reg)
            begin
                window_elapsed_next = win_sum;
                if (win_sum >= {{(TIMER_W - MS_W){1'b0}}, window_len_reg})
                begin
                    missed_next         = lost;
                    window_open_next    = 1'b0;
                    window_elapsed_next = '0;
                    if (lost != '0)
                    begin
                        rep      = REPORT_TIMEOUT;
                        reported = lost;
                        fail     = 1'b1;
                    end
                end
            end
            interval_elapsed_next = int_sum;
            if (int_sum >= {{(TIMER_W - MS_W){1'b0}}, interval_reg})
            begin
                interval_elapsed_next = int_sum - {{(TIMER_W - MS_W){1'b0}}, interval_reg};
                if (!window_open_next)
                begin
                    expected_latch_next = expected_mask_reg & NODE_MASK_ALL;
                    received_next       = '0;
                    missed_next         = '0;
                    window_elapsed_next = '0;
                    window_open_next    = 1'b1;
                    frame               = FRAME_REQUEST;
                end
            end
        end
        else
        begin
            case (item.msg_kind)
                MSG_REQUEST:
                begin
                    frame = FRAME_OK;
                end
                MSG_ERROR:
                begin
                    missed_next         = src_match;
                    window_open_next    = 1'b0;
                    window_elapsed_next = '0;
                    rep                 = REPORT_ERROR;
                    reported            = src_match;
                    fail                = 1'b1;
                end
                MSG_OK:
                begin
                    if (src_match != '0)
                    begin
                        received_next = rcv_tmp;
                        missed_next   = '0;
                        if ((rcv_tmp & expected_latch_reg) == expected_latch_reg)
                        begin
                            window_open_next    = 1'b0;
                            window_elapsed_next = '0;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end

        fault_next = fault_reg || (fail && fault_mode_reg);

        result.send_frame    = frame;
        result.report        = rep;
        result.missed_mask   = (rep != REPORT_NONE) ? reported : missed_next;
        result.received_mask = received_next;
        result.window_open   = window_open_next;
        result.fault_raised  = fail && fault_mode_reg && !fault_reg;
        result.fault_latched = fault_next;
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg      <= INTERVAL_MS_RESET;
            window_len_reg    <= REPLY_WINDOW_MS_RESET;
            expected_mask_reg <= EXPECTED_MASK_RESET;
            fault_mode_reg    <= FAULT_MODE_RESET;
            node_id_reg[0]    <= CAR_ID_RESET;
            node_id_reg[1]    <= FLOOR_ONE_ID_RESET;
            node_id_reg[2]    <= FLOOR_TWO_ID_RESET;
            node_id_reg[3]    <= FLOOR_THREE_ID_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_INTERVAL:     interval_reg      <= cfg_data[MS_W-1:0];
                REG_REPLY_WINDOW: window_len_reg    <= cfg_data[MS_W-1:0];
                REG_EXPECTED:     expected_mask_reg <= cfg_data[MASK_W-1:0];
                REG_FAULT_MODE:   fault_mode_reg    <= cfg_data[0];
                REG_CAR_ID:       node_id_reg[0]    <= cfg_data[ID_W-1:0];
                REG_FLOOR_ONE_ID: node_id_reg[1]    <= cfg_data[ID_W-1:0];
                REG_FLOOR_TWO_ID: node_id_reg[2]    <= cfg_data[ID_W-1:0];
                REG_FLOOR_THR_ID: node_id_reg[3]    <= cfg_data[ID_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // supervisor state and output valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_elapsed_reg <= '0;
            window_elapsed_reg   <= '0;
            window_open_reg      <= 1'b0;
            expected_latch_reg   <= '0;
            received_reg         <= '0;
            missed_reg           <= '0;
            fault_reg            <= 1'b0;
            out_valid_reg        <= 1'b0;
            skid_valid_reg       <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                interval_elapsed_reg <= interval_elapsed_next;
                window_elapsed_reg   <= window_elapsed_next;
                window_open_reg      <= window_open_next;
                expected_latch_reg   <= expected_latch_next;
                received_reg         <= received_next;
                missed_reg           <= missed_next;
                fault_reg            <= fault_next;
            end
            if (!out_valid_reg || take)
            begin
                if (skid_valid_reg)
                begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
                else
                begin
                    out_valid_reg <= accept;
                end
            end
            else if (accept)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    // result payloads
    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || take)
        begin
            if (skid_valid_reg)
            begin
                out_item_reg <= skid_item_reg;
            end
            else if (accept)
            begin
                out_item_reg <= result;
            end
        end
        else if (accept)
        begin
            skid_item_reg <= result;
        end
    end

`ifndef SYNTHESIS
    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held while result register empty");

    a_stall_to_skid: assert property (@(posedge clk) disable iff (!rst_n)
        accept && out_valid_reg && !out_ch.ready |=> skid_valid_reg)
        else $error("item accepted under stall not kept in skid entry");

    a_fault_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        fault_reg |=> fault_reg)
        else $error("latched fault cleared");

    a_closed_timer_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !window_open_reg |-> window_elapsed_reg == '0)
        else $error("window timer running while window closed");
`endif

endmodule

/* dv/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench for node_heartbeat_supervisor_top
// Drives ticks and heartbeat messages, mirrors the supervisor state in a
// local predictor and checks every result item, field by field, in order.
// ----------------------------------------------------------------------------
module tb;
    import nhs_pkg::*;

    localparam int QUIET_LIMIT  = 2000;
    localparam int STALL_CYCLES = 120;
    localparam int MAX_REPORTED = 10;
    localparam int PHASE_ITEMS  = 205;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    nhs_chan_if #(.item_t(in_item_t))  in_ch ();
    nhs_chan_if #(.item_t(out_item_t)) out_ch ();

    node_heartbeat_supervisor_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // register mirror
    logic [MS_W-1:0]   cfg_interval;
    logic [MS_W-1:0]   cfg_window;
    logic [MASK_W-1:0] cfg_expect;
    logic              cfg_fault_mode;
    logic [ID_W-1:0]   node_id [NODE_IDS];

    // supervisor state mirror
    logic [TIMER_W-1:0] iv_elapsed;
    logic [TIMER_W-1:0] win_elapsed;
    logic               win_open;
    logic [MASK_W-1:0]  exp_latch;
    logic [MASK_W-1:0]  rcvd;
    logic [MASK_W-1:0]  missed;
    logic               fault;

    out_item_t pending_results [$];

    int  mismatches;
    int  n_items;
    int  n_requests;
    int  n_timeouts;
    int  n_errors;
    int  quiet_cycles;
    int  stall_asked;
    int  stall_done;
    int  hold_left;
    bit  steady;

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic logic [TIMER_W-1:0] timer_add(logic [TIMER_W-1:0] a,
                                                     logic [MS_W-1:0] b);
        logic [TIMER_W:0] s;
        s = {1'b0, a} + {{(TIMER_W + 1 - MS_W){1'b0}}, b};
        return s[TIMER_W] ? '1 : s[TIMER_W-1:0];
    endfunction

    function automatic logic [MASK_W-1:0] node_hit(logic [ID_W-1:0] src);
        for (int i = 0; i < NODE_MATCH_N; i++)
            if (node_id[i] == src)
                return MASK_W'(1 << i);
        return '0;
    endfunction

    function automatic logic latch_fault();
        if (!cfg_fault_mode || fault)
            return 1'b0;
        fault = 1'b1;
        return 1'b1;
    endfunction

    function automatic out_item_t supervise(in_item_t it);
        out_item_t         r;
        logic [MASK_W-1:0] shown;
        logic [MASK_W-1:0] hit;
        r     = '0;
        shown = '0;
        if (it.command == CMD_TICK) begin
            if (win_open) begin
                win_elapsed = timer_add(win_elapsed, it.elapsed_ms);
                if (win_elapsed >= {{(TIMER_W - MS_W){1'b0}}, cfg_window}) begin
                    missed      = exp_latch & ~rcvd;
                    win_open    = 1'b0;
                    win_elapsed = '0;
                    if (missed != '0) begin
                        r.report       = REPORT_TIMEOUT;
                        shown          = missed;
                        r.fault_raised = latch_fault();
                    end
                end
            end
            iv_elapsed = timer_add(iv_elapsed, it.elapsed_ms);
            if (iv_elapsed >= {{(TIMER_W - MS_W){1'b0}}, cfg_interval}) begin
                iv_elapsed = iv_elapsed - {{(TIMER_W - MS_W){1'b0}}, cfg_interval};
                if (!win_open) begin
                    exp_latch    = cfg_expect & NODE_MASK_ALL;
                    rcvd         = '0;
                    missed       = '0;
                    win_elapsed  = '0;
                    win_open     = 1'b1;
                    r.send_frame = FRAME_REQUEST;
                end
            end
        end
        else begin
            case (it.msg_kind)
                MSG_REQUEST: r.send_frame = FRAME_OK;
                MSG_ERROR:
                begin
                    missed         = node_hit(it.sender_id);
                    win_open       = 1'b0;
                    win_elapsed    = '0;
                    r.report       = REPORT_ERROR;
                    shown          = missed;
                    r.fault_raised = latch_fault();
                end
                MSG_OK:
                begin
                    hit = node_hit(it.sender_id);
                    if (hit != '0) begin
                        rcvd   = rcvd | hit;
                        missed = '0;
                        if ((rcvd & exp_latch) == exp_latch) begin
                            win_open    = 1'b0;
                            win_elapsed = '0;
                        end
                    end
                end
                default: ;
            endcase
        end
        r.missed_mask   = (r.report != REPORT_NONE) ? shown : missed;
        r.received_mask = rcvd;
        r.window_open   = win_open;
        r.fault_latched = fault;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic in_item_t make_tick(logic [MS_W-1:0] ms);
        in_item_t it;
        it.command    = CMD_TICK;
        it.elapsed_ms = ms;
        it.msg_kind   = 2'($urandom_range(0, 3));
        it.sender_id  = ID_W'($urandom_range(0, 65535));
        return it;
    endfunction

    function automatic in_item_t make_msg(msg_kind_t kind, logic [ID_W-1:0] src);
        in_item_t it;
        it.command    = CMD_MSG;
        it.elapsed_ms = MS_W'($urandom_range(0, 65535));
        it.msg_kind   = kind;
        it.sender_id  = src;
        return it;
    endfunction

    // mostly well-formed traffic: ticks sized to the timers, replies from
    // configured nodes; a few requests, errors, strangers and other kinds
    function automatic in_item_t random_item();
        int pick;
        int span;
        pick = $urandom_range(0, 99);
        span = ((cfg_window > cfg_interval) ? cfg_window : cfg_interval) / 3 + 1;
        if (pick < 45) begin
            pick = $urandom_range(0, 9);
            if (pick < 7)
                return make_tick(MS_W'($urandom_range(0, span)));
            else if (pick < 9)
                return make_tick(MS_W'($urandom_range(0, (2 * span > 65535) ? 65535 : 2 * span)));
            return make_tick(MS_W'($urandom_range(0, 65535)));
        end
        if (pick < 80)
            return make_msg(MSG_OK, node_id[$urandom_range(0, NODE_IDS - 1)]);
        if (pick < 88)
            return make_msg(MSG_REQUEST, ID_W'($urandom_range(0, 65535)));
        if (pick < 93)
            return make_msg(MSG_ERROR, ($urandom_range(0, 1) != 0)
                            ? node_id[$urandom_range(0, NODE_IDS - 1)]
                            : ID_W'($urandom_range(0, 65535)));
        if (pick < 96)
            return make_msg(MSG_OK, ID_W'($urandom_range(0, 65535)));
        return make_msg(MSG_OTHER, ID_W'($urandom_range(0, 65535)));
    endfunction

    // valid stays high between back-to-back items; lowered only on a gap
    task automatic send_item(input in_item_t it);
        out_item_t r;
        while (!steady && $urandom_range(0, 99) < 10) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.payload <= it;
        do
            @(posedge clk);
        while (!in_ch.ready);
        r = supervise(it);
        pending_results.push_back(r);
        n_items++;
        if (r.send_frame == FRAME_REQUEST)
            n_requests++;
        if (r.report == REPORT_TIMEOUT)
            n_timeouts++;
        if (r.report == REPORT_ERROR)
            n_errors++;
    endtask

    // sender goes quiet until every pending result has been taken
    task automatic settle();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            REG_INTERVAL:     cfg_interval   = val;
            REG_REPLY_WINDOW: cfg_window     = val;
            REG_EXPECTED:     cfg_expect     = val[MASK_W-1:0];
            REG_FAULT_MODE:   cfg_fault_mode = val[0];
            REG_CAR_ID:       node_id[0]     = val;
            REG_FLOOR_ONE_ID: node_id[1]     = val;
            REG_FLOOR_TWO_ID: node_id[2]     = val;
            REG_FLOOR_THR_ID: node_id[3]     = val;
            default: ;
        endcase
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------
    function automatic string show_result(out_item_t r);
        return $sformatf("frame=%0d report=%0d missed=%h rcvd=%h win=%0d raised=%0d latched=%0d",
                         r.send_frame, r.report, r.missed_mask, r.received_mask,
                         r.window_open, r.fault_raised, r.fault_latched);
    endfunction

    task automatic flag_mismatch(input string what, input out_item_t want,
                                 input out_item_t got);
        mismatches++;
        if (mismatches <= MAX_REPORTED)
            $display("%0t %s\n    expected %s\n    actual   %s", $time, what,
                     show_result(want), show_result(got));
    endtask

    always @(posedge clk) begin : result_check
        out_item_t want;
        out_item_t got;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            got = out_ch.payload;
            if (pending_results.size() == 0)
                flag_mismatch("result item with nothing pending", '0, got);
            else begin
                want = pending_results.pop_front();
                if (got.send_frame    !== want.send_frame    ||
                    got.report        !== want.report        ||
                    got.missed_mask   !== want.missed_mask   ||
                    got.received_mask !== want.received_mask ||
                    got.window_open   !== want.window_open   ||
                    got.fault_raised  !== want.fault_raised  ||
                    got.fault_latched !== want.fault_latched)
                    flag_mismatch("result item mismatch", want, got);
            end
        end
    end

    // receiver: random stalls, steady stretches, and long hold-offs on request
    always @(posedge clk) begin
        if (stall_asked > stall_done) begin
            stall_done = stall_done + 1;
            hold_left  = STALL_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            out_ch.ready <= 1'b0;
        end
        else if (steady)
            out_ch.ready <= 1'b1;
        else
            out_ch.ready <= ($urandom_range(0, 99) >= 10);
    end

    always @(posedge clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Timeout: no item moved for %0d cycles", QUIET_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    // reset settings: request, replies, OK frame, close on all replied
    task automatic test_request_cycle();
        send_item(make_tick(16'd0));
        send_item(make_tick(16'd3000));
        send_item(make_msg(MSG_OK, 16'd1));
        send_item(make_msg(MSG_OK, 16'd1));
        send_item(make_msg(MSG_REQUEST, 16'd2));
        send_item(make_msg(MSG_OK, 16'd2));
        send_item(make_msg(MSG_OK, 16'd3));
        send_item(make_msg(MSG_OK, 16'd4));
        // reply with the window closed still marks the node
        send_item(make_msg(MSG_OK, 16'd2));
    endtask

    // node error with fault mode off, then first latch, then already latched
    task automatic test_fault_latch();
        settle();
        write_reg(REG_FAULT_MODE, 16'd0);
        send_item(make_msg(MSG_ERROR, 16'd3));
        settle();
        write_reg(REG_FAULT_MODE, 16'd1);
        send_item(make_msg(MSG_ERROR, 16'hFFFF));
        send_item(make_msg(MSG_ERROR, 16'd1));
    endtask

    // timeout and fresh request on one tick, ignored messages, largest tick
    task automatic test_timeout_restart();
        settle();
        write_reg(REG_INTERVAL, 16'd100);
        write_reg(REG_REPLY_WINDOW, 16'd100);
        send_item(make_tick(16'd100));
        send_item(make_msg(MSG_OK, 16'd1));
        send_item(make_tick(16'd100));
        send_item(make_msg(MSG_OTHER, 16'hFFFF));
        send_item(make_msg(MSG_OK, 16'h1234));
        send_item(make_tick(16'hFFFF));
    endtask

    // zero interval and window, empty expected set, shared identifiers
    task automatic test_zero_timers_shared_ids();
        settle();
        write_reg(REG_INTERVAL, 16'd0);
        write_reg(REG_REPLY_WINDOW, 16'd0);
        write_reg(REG_EXPECTED, 16'd0);
        write_reg(REG_CAR_ID, 16'hFFFF);
        write_reg(REG_FLOOR_ONE_ID, 16'hFFFF);
        write_reg(REG_FLOOR_TWO_ID, 16'h0000);
        write_reg(REG_FLOOR_THR_ID, 16'h0000);
        send_item(make_tick(16'd0));
        send_item(make_tick(16'd0));
        send_item(make_msg(MSG_OK, 16'hFFFF));
        send_item(make_msg(MSG_ERROR, 16'h0000));
        settle();
        write_reg(REG_EXPECTED, 16'd15);
        send_item(make_tick(16'd0));
        send_item(make_tick(16'd0));
    endtask

    task automatic program_random(input int phase);
        logic [CFG_DATA_W-1:0] ids [NODE_IDS];
        for (int i = 0; i < NODE_IDS; i++)
            ids[i] = CFG_DATA_W'($urandom_range(0, 65535));
        if (phase == 3)
            ids[2] = ids[1];
        case (phase)
            0:
            begin
                write_reg(REG_INTERVAL, 16'hFFFF);
                write_reg(REG_REPLY_WINDOW, 16'hFFFF);
            end
            1:
            begin
                write_reg(REG_INTERVAL, 16'd1);
                write_reg(REG_REPLY_WINDOW, 16'd1);
            end
            default:
            begin
                write_reg(REG_INTERVAL, CFG_DATA_W'($urandom_range(1, 400)));
                write_reg(REG_REPLY_WINDOW, CFG_DATA_W'($urandom_range(1, 400)));
            end
        endcase
        write_reg(REG_EXPECTED, CFG_DATA_W'($urandom_range(0, 15)));
        write_reg(REG_FAULT_MODE, CFG_DATA_W'($urandom_range(0, 1)));
        write_reg(REG_CAR_ID, ids[0]);
        write_reg(REG_FLOOR_ONE_ID, ids[1]);
        write_reg(REG_FLOOR_TWO_ID, ids[2]);
        write_reg(REG_FLOOR_THR_ID, ids[3]);
    endtask

    // output held off while the sender keeps offering, then a full drain
    task automatic test_backpressure();
        settle();
        program_random(4);
        steady = 1'b1;
        stall_asked++;
        repeat (40)
            send_item(random_item());
        settle();
        repeat (10)
            send_item(random_item());
        steady = 1'b0;
    endtask

    task automatic test_random_phases();
        for (int phase = 0; phase < 6; phase++) begin
            settle();
            program_random(phase);
            steady = (phase == 2);
            repeat (PHASE_ITEMS)
                send_item(random_item());
        end
        steady = 1'b0;
    endtask

    initial begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        in_ch.valid    = 1'b0;
        in_ch.payload  = '0;
        out_ch.ready   = 1'b0;
        cfg_interval   = INTERVAL_MS_RESET;
        cfg_window     = REPLY_WINDOW_MS_RESET;
        cfg_expect     = EXPECTED_MASK_RESET;
        cfg_fault_mode = FAULT_MODE_RESET;
        node_id[0]     = CAR_ID_RESET;
        node_id[1]     = FLOOR_ONE_ID_RESET;
        node_id[2]     = FLOOR_TWO_ID_RESET;
        node_id[3]     = FLOOR_THREE_ID_RESET;
        iv_elapsed     = '0;
        win_elapsed    = '0;
        win_open       = 1'b0;
        exp_latch      = '0;
        rcvd           = '0;
        missed         = '0;
        fault          = 1'b0;
        mismatches     = 0;
        n_items        = 0;
        n_requests     = 0;
        n_timeouts     = 0;
        n_errors       = 0;
        quiet_cycles   = 0;
        stall_asked    = 0;
        stall_done     = 0;
        hold_left      = 0;
        steady         = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_request_cycle();
        test_fault_latch();
        test_timeout_restart();
        test_zero_timers_shared_ids();
        test_backpressure();
        test_random_phases();

        settle();
        repeat (8) @(posedge clk);
        while (pending_results.size() != 0)
            flag_mismatch("result item never arrived", pending_results.pop_front(), '0);

        $display("Ran %0d items over several register settings: %0d requests, %0d timeouts,",
                 n_items, n_requests, n_timeouts);
        $display("%0d node errors reported, %0d mismatches", n_errors, mismatches);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
